// ----- hdl/cqs_pkg.sv -----
// shared types, codes and defaults for the circular queue with scan
`timescale 1ns / 1ps

package cqs_pkg;

  // default number of entries
  localparam int CQS_DEPTH = 16;

  // field widths fixed by the interface
  localparam int WORD_W = 32;
  localparam int RES_W  = 5;

  // opcodes
  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_MINMAX = 2'd2;
  localparam logic [1:0] OP_COUNT  = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ_WAIT,
    S_SCAN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       enq;
    logic       deq;
    logic       scan_start;
    logic       scan_run;
    logic       finish;
    logic [1:0] fin_status;
  } cqs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       scan_done;
  } cqs_stat_t;

endpackage

// ----- hdl/cqs_ctrl.sv -----
// controller state machine for the circular queue with scan
`timescale 1ns / 1ps

module cqs_ctrl
  import cqs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  cqs_stat_t stat,
  output cqs_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat.op) inside
          OP_ENQ: state_nxt = S_IDLE;
          OP_DEQ: state_nxt = stat.empty ? S_IDLE : S_DEQ_WAIT;
          OP_MINMAX, OP_COUNT: state_nxt = stat.empty ? S_IDLE : S_SCAN;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DEQ_WAIT: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.fin_status = STAT_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        unique case (stat.op) inside
          OP_ENQ: begin
            cmd.finish = 1'b1;
            if (stat.full) cmd.fin_status = STAT_FULL;
            else           cmd.enq        = 1'b1;
          end
          OP_DEQ: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = STAT_EMPTY;
            end else begin
              cmd.deq = 1'b1;
            end
          end
          OP_MINMAX, OP_COUNT: begin
            if (stat.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = STAT_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
            end
          end
          default: cmd.finish = 1'b1;
        endcase
      end
      S_DEQ_WAIT: begin
        cmd.finish = 1'b1;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.finish   = stat.scan_done;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/cqs_dpath.sv -----
// datapath: entry memory, pointers, fill count, scan unit and result registers
`timescale 1ns / 1ps

module cqs_dpath
  import cqs_pkg::*;
#(
  parameter int DEPTH = CQS_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [1:0]               in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  input  cqs_cmd_t                 cmd,
  output cqs_stat_t                stat,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic signed [WORD_W-1:0] out_min_value,
  output logic signed [WORD_W-1:0] out_max_value,
  output logic [RES_W-1:0]         out_match_count,
  output logic [RES_W-1:0]         out_occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // wrap-around increment of a slot index
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
    next_slot = (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  logic [WORD_W-1:0]        mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic [1:0]               op_r;
  logic signed [WORD_W-1:0] val_r;
  logic [AW-1:0]            head_r, tail_r, ptr_r;
  logic [CW-1:0]            count_r, count_nxt, left_r, mc_r;
  logic                     pend_r, first_r;
  logic signed [WORD_W-1:0] min_r, max_r;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     scan_issue;
  logic [CW+RES_W-1:0]      occ_ext, mc_ext;

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= in_value;
    end
  end

  assign stat.op        = op_r;
  assign stat.full      = (count_r == FULL_CNT);
  assign stat.empty     = (count_r == '0);
  assign stat.scan_done = (left_r == '0) && !pend_r;

  // fill count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.enq)      count_nxt = count_r + 1'b1;
    else if (cmd.deq) count_nxt = count_r - 1'b1;
  end

  // head, tail and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.enq) tail_r <= next_slot(tail_r);
      if (cmd.deq) head_r <= next_slot(head_r);
    end
  end

  // single read port shared by dequeue and scan
  assign scan_issue = cmd.scan_run && (left_r != '0);
  assign rd_en      = cmd.deq || scan_issue;
  assign rd_addr    = cmd.deq ? head_r : ptr_r;

  // entry memory
  always_ff @(posedge clk) begin
    if (cmd.enq) mem[tail_r] <= val_r;
    if (rd_en)   rd_data_r <= mem[rd_addr];
  end

  // scan walker: one read issued per cycle, its data handled from the read register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_start) begin
      left_r <= count_r;
      pend_r <= 1'b0;
    end else if (cmd.scan_run) begin
      pend_r <= scan_issue;
      if (scan_issue) left_r <= left_r - 1'b1;
    end
  end

  // scan pointer and accumulators
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr_r   <= head_r;
      first_r <= 1'b1;
      mc_r    <= '0;
    end else if (cmd.scan_run) begin
      if (scan_issue) ptr_r <= next_slot(ptr_r);
      if (pend_r) begin
        first_r <= 1'b0;
        if (rd_data_r == val_r) mc_r <= mc_r + 1'b1;
        if (first_r) begin
          min_r <= rd_data_r;
          max_r <= rd_data_r;
        end else begin
          if (rd_data_r < min_r) min_r <= rd_data_r;
          if (rd_data_r > max_r) max_r <= rd_data_r;
        end
      end
    end
  end

  // counts keep only their low bits on the result ports
  assign occ_ext = {{RES_W{1'b0}}, count_nxt};
  assign mc_ext  = {{RES_W{1'b0}}, mc_r};

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status      <= cmd.fin_status;
      out_data_out    <= '0;
      out_min_value   <= '0;
      out_max_value   <= '0;
      out_match_count <= '0;
      out_occupancy   <= occ_ext[RES_W-1:0];
      if (cmd.fin_status == STAT_OK) begin
        if (op_r == OP_DEQ) out_data_out <= rd_data_r;
        if (op_r == OP_MINMAX) begin
          out_min_value <= min_r;
          out_max_value <= max_r;
        end
        if (op_r == OP_COUNT) out_match_count <= mc_ext[RES_W-1:0];
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
    end
  end

  // fill count never goes past the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above depth");

  // a refused enqueue is reported only on a full queue
  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> count_r == FULL_CNT)
    else $error("full status with room left");

  // an empty report is given only on an empty queue
  a_empty_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |-> count_r == '0)
    else $error("empty status with entries held");

  // the match count of a completed scan cannot exceed the entries walked
  a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (op_r == OP_COUNT) && (out_status == STAT_OK) |-> mc_r <= count_r)
    else $error("match count above occupancy");

endmodule

// ----- hdl/circular_queue_with_scan.sv -----
// top level of the circular queue with scan
`timescale 1ns / 1ps

// Circular FIFO of DEPTH signed 32-bit words with enqueue, dequeue, min/max
// scan and key-match count. A command beat is taken when start is high and
// busy is low; every beat gives exactly one result, shown for a single cycle
// with out_valid high, and the receiver has no way to hold it. Enqueue, and
// any refused command, keeps busy high through the execute state only;
// dequeue adds a wait state for the memory read; a scan stays in the scan
// state until the stored words, read one per cycle through the single read
// port of the entry memory, have all been handled. The result strobe
// is high in the first cycle with busy low; a new beat may be taken then.
module circular_queue_with_scan
  import cqs_pkg::*;
#(
  parameter int DEPTH = CQS_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [WORD_W-1:0] out_data_out,
  output logic signed [WORD_W-1:0] out_min_value,
  output logic signed [WORD_W-1:0] out_max_value,
  output logic [RES_W-1:0]         out_match_count,
  output logic [RES_W-1:0]         out_occupancy
);

  cqs_cmd_t  cmd;
  cqs_stat_t stat;

  // controller
  cqs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  cqs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_min_value   (out_min_value),
    .out_max_value   (out_max_value),
    .out_match_count (out_match_count),
    .out_occupancy   (out_occupancy)
  );

endmodule
